// ===== design/cdc_pkg.sv =====
// Package for the calendar date counter: item layouts, command codes,
// date constants and the month-length function. No dependencies.
`default_nettype none

package cdc_pkg;

	localparam int KIND_W      = 3;
	localparam int MONTH_W     = 4;
	localparam int DAY_W       = 5;
	localparam int ARG_YEAR_W  = 16;
	// widest year the block can be built with
	localparam int YEAR_WIDE_W = 32;

	localparam logic [KIND_W-1:0] KIND_SET  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_INC  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DEC  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_READ = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CMP  = 3'd4;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
	localparam logic [DAY_W-1:0] DAYS_31   = 5'd31;
	localparam logic [DAY_W-1:0] DAYS_30   = 5'd30;
	localparam logic [DAY_W-1:0] DAYS_29   = 5'd29;
	localparam logic [DAY_W-1:0] DAYS_28   = 5'd28;

	localparam logic [YEAR_WIDE_W-1:0] RESET_YEAR = 32'd2000;

	typedef struct packed {
		logic [KIND_W-1:0]     kind;
		logic [MONTH_W-1:0]    arg_month;
		logic [DAY_W-1:0]      arg_day;
		logic [ARG_YEAR_W-1:0] arg_year;
	} cmd_t;

	typedef struct packed {
		logic [MONTH_W-1:0]    cur_month;
		logic [DAY_W-1:0]      cur_day;
		logic [ARG_YEAR_W-1:0] cur_year;
		logic                  ok;
	} res_t;

	// Days in a month; out-of-range months give 31.
	function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		case (m) inside
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_30;
			MONTH_FEB: len = leap ? DAYS_29 : DAYS_28;
			default: len = DAYS_31;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

// ===== design/cdc_cmd_if.sv =====
// Command channel of the calendar date counter: valid/ready plus one command item.
// Depends on cdc_pkg.
`default_nettype none

interface cdc_cmd_if;
	import cdc_pkg::*;

	logic valid;
	logic ready;
	cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/cdc_res_if.sv =====
// Result channel of the calendar date counter: valid/ready plus one result item.
// Depends on cdc_pkg.
`default_nettype none

interface cdc_res_if;
	import cdc_pkg::*;

	logic valid;
	logic ready;
	res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/cdc_date_step.sv =====
// Next-date logic: applies one command to the stored date, purely combinational.
// Depends on cdc_pkg.
`default_nettype none

module cdc_date_step #(
	parameter int YEAR_BITS = 16
) (
	input  wire logic [cdc_pkg::KIND_W-1:0]  kind,
	input  wire logic [cdc_pkg::MONTH_W-1:0] arg_month,
	input  wire logic [cdc_pkg::DAY_W-1:0]   arg_day,
	input  wire logic [YEAR_BITS-1:0]        arg_year,
	input  wire logic [cdc_pkg::MONTH_W-1:0] month,
	input  wire logic [cdc_pkg::DAY_W-1:0]   day,
	input  wire logic [YEAR_BITS-1:0]        year,
	output logic      [cdc_pkg::MONTH_W-1:0] next_month,
	output logic      [cdc_pkg::DAY_W-1:0]   next_day,
	output logic      [YEAR_BITS-1:0]        next_year,
	output logic                             ok
);
	import cdc_pkg::*;

	logic [DAY_W-1:0]   cur_len;
	logic [DAY_W-1:0]   arg_len;
	logic [MONTH_W-1:0] prev_month;
	logic [YEAR_BITS-1:0] prev_year;
	logic               arg_valid;

	assign cur_len = month_length(month, year[1:0] == 2'd0);
	assign arg_len = month_length(arg_month, arg_year[1:0] == 2'd0);
	assign arg_valid = (arg_month >= MONTH_JAN) && (arg_month <= MONTH_DEC) &&
		(arg_day >= DAY_FIRST) && (arg_day <= arg_len);

	// month and year reached by stepping back over the first of a month
	assign prev_month = (month > MONTH_JAN) ? MONTH_W'(month - MONTH_JAN) : MONTH_DEC;
	assign prev_year  = (month > MONTH_JAN) ? year : YEAR_BITS'(year - 1'b1);

	always_comb begin
		next_month = month;
		next_day   = day;
		next_year  = year;
		ok         = 1'b1;
		case (kind)
			KIND_SET: begin
				ok = arg_valid;
				if (arg_valid) begin
					next_month = arg_month;
					next_day   = arg_day;
					next_year  = arg_year;
				end
			end
			KIND_INC: begin
				if (day >= cur_len) begin
					next_day = DAY_FIRST;
					if (month >= MONTH_DEC) begin
						next_month = MONTH_JAN;
						next_year  = YEAR_BITS'(year + 1'b1);
					end else begin
						next_month = MONTH_W'(month + 1'b1);
					end
				end else begin
					next_day = DAY_W'(day + 1'b1);
				end
			end
			KIND_DEC: begin
				if (day > DAY_FIRST) begin
					next_day = DAY_W'(day - 1'b1);
				end else begin
					next_month = prev_month;
					next_year  = prev_year;
					next_day   = month_length(prev_month, prev_year[1:0] == 2'd0);
				end
			end
			KIND_CMP: begin
				ok = (month == arg_month) && (day == arg_day) && (year == arg_year);
			end
			// read and the unused codes leave the date alone
			default: begin
				ok = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/calendar_date_counter_top.sv =====
// Calendar date counter top level: input register, date registers, result register.
// Depends on cdc_pkg, cdc_cmd_if, cdc_res_if and cdc_date_step.
//
// The block keeps one date (month, day, year), 1/1/2000 after reset, and answers
// every command item with exactly one result item holding the date after the
// command and an ok flag. It takes one item per clock cycle while its results
// are taken. A result is registered: an accepted command waits in the input
// register while the combinational date update computes the next date, and both
// the date and the result register load when the item moves on. A result that is
// not taken holds the input register, which stalls the command side. The year
// register is YEAR_BITS wide and wraps at 2^YEAR_BITS; the year fields on the
// ports are 16 bits, zero-extended or truncated to the register width.
`default_nettype none

module calendar_date_counter_top #(
	parameter int YEAR_BITS = 16
) (
	input wire logic  clk,
	input wire logic  arst_n,
	cdc_cmd_if.sink   cmd,
	cdc_res_if.source res
);
	import cdc_pkg::*;

	localparam logic [YEAR_BITS-1:0] YEAR_INIT = RESET_YEAR[YEAR_BITS-1:0];

	logic                 valid_s1;
	cmd_t                 cmd_s1;
	logic                 res_valid_q;
	res_t                 res_q;
	logic [MONTH_W-1:0]   month_q;
	logic [DAY_W-1:0]     day_q;
	logic [YEAR_BITS-1:0] year_q;

	logic                   advance;
	logic [YEAR_WIDE_W-1:0] arg_year_wide;
	logic [YEAR_WIDE_W-1:0] next_year_wide;
	logic [MONTH_W-1:0]     next_month;
	logic [DAY_W-1:0]       next_day;
	logic [YEAR_BITS-1:0]   next_year;
	logic                   next_ok;

	// move the held item into the result register when that register frees up
	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || advance;

	assign arg_year_wide  = YEAR_WIDE_W'(cmd_s1.arg_year);
	assign next_year_wide = YEAR_WIDE_W'(next_year);

	cdc_date_step #(
		.YEAR_BITS(YEAR_BITS)
	) u_step (
		.kind      (cmd_s1.kind),
		.arg_month (cmd_s1.arg_month),
		.arg_day   (cmd_s1.arg_day),
		.arg_year  (arg_year_wide[YEAR_BITS-1:0]),
		.month     (month_q),
		.day       (day_q),
		.year      (year_q),
		.next_month(next_month),
		.next_day  (next_day),
		.next_year (next_year),
		.ok        (next_ok)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			month_q     <= MONTH_JAN;
			day_q       <= DAY_FIRST;
			year_q      <= YEAR_INIT;
		end else begin
			if (cmd.ready) begin
				valid_s1 <= cmd.valid;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
				month_q     <= next_month;
				day_q       <= next_day;
				year_q      <= next_year;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers: no reset
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= cmd.data;
		end
		if (advance) begin
			res_q.cur_month <= next_month;
			res_q.cur_day   <= next_day;
			res_q.cur_year  <= next_year_wide[ARG_YEAR_W-1:0];
			res_q.ok        <= next_ok;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

endmodule

`default_nettype wire
